// ===== rtl/core/bdq_pkg.sv =====
`timescale 1ns / 1ps

package bdq_pkg;

    localparam int DEF_CAPACITY = 32;

    localparam int REQ_W    = 3;
    localparam int POS_W    = 7;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 3;
    localparam int FILL_W   = 6;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH_BACK  = 3'd0,
        REQ_PUSH_FRONT = 3'd1,
        REQ_POP_BACK   = 3'd2,
        REQ_POP_FRONT  = 3'd3,
        REQ_READ_AT    = 3'd4,
        REQ_WRITE_AT   = 3'd5,
        REQ_READ_BACK  = 3'd6
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK      = 3'd0,
        STAT_FULL    = 3'd1,
        STAT_EMPTY   = 3'd2,
        STAT_NEG     = 3'd3,
        STAT_RANGE   = 3'd4,
        STAT_BACKNUM = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_EXEC = 2'd1,
        ST_RESP = 2'd2
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;   // latch incoming item
        logic exec;   // run the request against the ring
    } t_cmd;

endpackage

// ===== rtl/core/bdq_if.sv =====
`timescale 1ns / 1ps

interface bdq_req_if;
    logic                                   valid;
    logic                                   ready;
    logic        [bdq_pkg::REQ_W-1:0]       req_type;
    logic signed [bdq_pkg::POS_W-1:0]       position;
    logic signed [bdq_pkg::DATA_W-1:0]      value;

    modport source (output valid, output req_type, output position, output value,
                    input ready);
    modport sink   (input valid, input req_type, input position, input value,
                    output ready);
endinterface

interface bdq_rsp_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [bdq_pkg::DATA_W-1:0]      read_value;
    logic        [bdq_pkg::STATUS_W-1:0]    status;
    logic        [bdq_pkg::FILL_W-1:0]      fill_count;

    modport source (output valid, output read_value, output status, output fill_count,
                    input ready);
    modport sink   (input valid, input read_value, input status, input fill_count,
                    output ready);
endinterface

// ===== rtl/core/bdq_ctrl.sv =====
`timescale 1ns / 1ps

module bdq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output bdq_pkg::t_cmd o_cmd
);

    bdq_pkg::t_state r_state;
    bdq_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bdq_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            bdq_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = bdq_pkg::ST_EXEC;
            end
            bdq_pkg::ST_EXEC: begin
                n_state = bdq_pkg::ST_RESP;
            end
            bdq_pkg::ST_RESP: begin
                if (i_out_ready) n_state = bdq_pkg::ST_IDLE;
            end
            default: begin
                n_state = bdq_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        case (r_state)
            bdq_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            bdq_pkg::ST_EXEC: begin
                o_cmd.exec = 1'b1;
            end
            bdq_pkg::ST_RESP: begin
                o_out_valid = 1'b1;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== rtl/core/bdq_dp.sv =====
`timescale 1ns / 1ps

module bdq_dp #(
    parameter int CAPACITY = bdq_pkg::DEF_CAPACITY
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  bdq_pkg::t_cmd                       i_cmd,
    input  logic        [bdq_pkg::REQ_W-1:0]    i_req_type,
    input  logic signed [bdq_pkg::POS_W-1:0]    i_position,
    input  logic signed [bdq_pkg::DATA_W-1:0]   i_value,
    output logic signed [bdq_pkg::DATA_W-1:0]   o_read_value,
    output logic        [bdq_pkg::STATUS_W-1:0] o_status,
    output logic        [bdq_pkg::FILL_W-1:0]   o_fill_count
);

    localparam int PW = $clog2(CAPACITY);       // slot index
    localparam int CW = $clog2(CAPACITY + 1);   // element count
    localparam int EW = CW + bdq_pkg::POS_W;    // position compare width
    localparam int SW = CW + 1;                 // front + offset

    localparam logic [PW-1:0] LAST_SLOT = PW'(CAPACITY - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(CAPACITY);
    localparam logic [SW-1:0] CAP_S     = SW'(CAPACITY);

    logic signed [bdq_pkg::DATA_W-1:0] r_mem [CAPACITY];

    logic [bdq_pkg::REQ_W-1:0]         r_req;
    logic [bdq_pkg::POS_W-1:0]         r_pos;
    logic signed [bdq_pkg::DATA_W-1:0] r_val;

    logic [PW-1:0]                     r_front;
    logic [CW-1:0]                     r_count;
    bdq_pkg::t_status                  r_status;
    logic                              r_rd_ok;
    logic signed [bdq_pkg::DATA_W-1:0] r_rd_data;

    logic [PW-1:0]    n_front;
    logic [CW-1:0]    n_count;
    bdq_pkg::t_status n_status;
    logic             n_rd_ok;

    logic          mem_we;
    logic          mem_re;
    logic          use_front_dec;
    logic [CW-1:0] offset;
    logic [EW-1:0] pos_w;
    logic [EW-1:0] count_w;
    logic [PW-1:0] front_dec;
    logic [PW-1:0] front_inc;
    logic [SW-1:0] slot_sum;
    logic [SW-1:0] slot_wrap;
    logic [PW-1:0] mem_addr;
    logic          is_full;
    logic          is_empty;

    assign pos_w     = {{CW{r_pos[bdq_pkg::POS_W-1]}}, r_pos};
    assign count_w   = EW'(r_count);
    assign front_dec = (r_front == '0) ? LAST_SLOT : r_front - 1'b1;
    assign front_inc = (r_front == LAST_SLOT) ? '0 : r_front + 1'b1;
    assign is_full   = (r_count == FULL_CNT);
    assign is_empty  = (r_count == '0);

    // ring slot: front + offset < 2*CAPACITY, so one conditional subtract wraps it
    assign slot_sum  = SW'(r_front) + SW'(offset);
    assign slot_wrap = (slot_sum >= CAP_S) ? slot_sum - CAP_S : slot_sum;
    assign mem_addr  = use_front_dec ? front_dec : slot_wrap[PW-1:0];

    always_comb begin
        n_front       = r_front;
        n_count       = r_count;
        n_status      = bdq_pkg::STAT_OK;
        n_rd_ok       = 1'b0;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        use_front_dec = 1'b0;
        offset        = r_count;
        case (bdq_pkg::t_req'(r_req))
            bdq_pkg::REQ_PUSH_BACK: begin
                if (is_full) begin
                    n_status = bdq_pkg::STAT_FULL;
                end else begin
                    mem_we  = 1'b1;
                    n_count = r_count + 1'b1;
                end
            end
            bdq_pkg::REQ_PUSH_FRONT: begin
                if (is_full) begin
                    n_status = bdq_pkg::STAT_FULL;
                end else begin
                    mem_we        = 1'b1;
                    use_front_dec = 1'b1;
                    n_front       = front_dec;
                    n_count       = r_count + 1'b1;
                end
            end
            bdq_pkg::REQ_POP_BACK: begin
                if (is_empty) begin
                    n_status = bdq_pkg::STAT_EMPTY;
                end else begin
                    n_count = r_count - 1'b1;
                end
            end
            bdq_pkg::REQ_POP_FRONT: begin
                if (is_empty) begin
                    n_status = bdq_pkg::STAT_EMPTY;
                end else begin
                    n_front = front_inc;
                    n_count = r_count - 1'b1;
                end
            end
            bdq_pkg::REQ_READ_AT, bdq_pkg::REQ_WRITE_AT: begin
                offset = pos_w[CW-1:0];
                if (r_pos[bdq_pkg::POS_W-1]) begin
                    n_status = bdq_pkg::STAT_NEG;
                end else if (pos_w >= count_w) begin
                    n_status = bdq_pkg::STAT_RANGE;
                end else if (bdq_pkg::t_req'(r_req) == bdq_pkg::REQ_READ_AT) begin
                    mem_re  = 1'b1;
                    n_rd_ok = 1'b1;
                end else begin
                    mem_we = 1'b1;
                end
            end
            bdq_pkg::REQ_READ_BACK: begin
                offset = r_count - pos_w[CW-1:0];
                if (r_pos[bdq_pkg::POS_W-1] || pos_w == '0 || pos_w > count_w) begin
                    n_status = bdq_pkg::STAT_BACKNUM;
                end else begin
                    mem_re  = 1'b1;
                    n_rd_ok = 1'b1;
                end
            end
            default: begin
                n_status = bdq_pkg::STAT_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_front <= n_front;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req_type;
            r_pos <= i_position;
            r_val <= i_value;
        end
        if (i_cmd.exec) begin
            r_status <= n_status;
            r_rd_ok  <= n_rd_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && mem_we) begin
            r_mem[mem_addr] <= r_val;
        end
        if (i_cmd.exec && mem_re) begin
            r_rd_data <= r_mem[mem_addr];
        end
    end

    assign o_read_value = r_rd_ok ? r_rd_data : '0;
    assign o_status     = r_status;
    assign o_fill_count = bdq_pkg::FILL_W'(r_count);

endmodule

// ===== rtl/core/bounded_deque_with_index_access_top.sv =====
`timescale 1ns / 1ps

// The request item is latched in the controller's idle state, run against the ring
// in its execute state and presented in its respond state; no new item is taken
// until the result has been taken, so only one item is in flight.
// Reset (sync, active low) empties the deque and returns the pointer to slot 0;
// the element memory is not cleared and needs no clearing pass.
module bounded_deque_with_index_access_top #(
    parameter int CAPACITY = bdq_pkg::DEF_CAPACITY
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    bdq_req_if.sink          i_req,
    bdq_rsp_if.source        o_rsp
);

    bdq_pkg::t_cmd cmd;

    bdq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (cmd)
    );

    bdq_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_req_type   (i_req.req_type),
        .i_position   (i_req.position),
        .i_value      (i_req.value),
        .o_read_value (o_rsp.read_value),
        .o_status     (o_rsp.status),
        .o_fill_count (o_rsp.fill_count)
    );

    // one item in flight: never take a request while a result is pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_req.ready && o_rsp.valid))
        else $error("request taken while result pending");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |-> ##2 o_rsp.valid)
        else $error("result not presented two cycles after accept");

    a_read_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.read_value != '0) |-> (o_rsp.status == bdq_pkg::STAT_OK))
        else $error("non-zero read data on a failed request");

    a_cmd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.exec |=> (o_rsp.valid && !cmd.load))
        else $error("execute not followed by response");

endmodule

// ===== sim/bounded_deque_with_index_access_top_tb.sv =====
`timescale 1ns / 1ps

module bounded_deque_with_index_access_top_tb;

    localparam int CAP            = bdq_pkg::DEF_CAPACITY;
    localparam int MAX_IDLE       = 11;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 8;
    localparam int RANDOM_ITEMS   = 500;

    // req_type 7 has no enum member; the block ignores it
    localparam logic [bdq_pkg::REQ_W-1:0] REQ_UNUSED = 3'd7;

    typedef struct {
        logic signed [bdq_pkg::DATA_W-1:0] rd;
        bdq_pkg::t_status                  st;
        logic [bdq_pkg::FILL_W-1:0]        fill;
    } t_deque_rsp;

    logic i_clk;
    logic i_rst_n;

    bdq_req_if req_bus ();
    bdq_rsp_if rsp_bus ();

    bounded_deque_with_index_access_top #(
        .CAPACITY (CAP)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    // shadow copy of the deque
    logic signed [bdq_pkg::DATA_W-1:0] shadow_store [CAP];
    int                                shadow_front;
    int                                shadow_count;

    t_deque_rsp pending_rsp [$];
    int         mismatch_count = 0;
    int         items_sent;
    int         results_seen = 0;
    int         status_seen [8] = '{default: 0};
    int         quiet_cycles = 0;
    bit         idle_on;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_deque_rsp predict_response(
            logic [bdq_pkg::REQ_W-1:0] kind,
            logic signed [bdq_pkg::POS_W-1:0] pos,
            logic signed [bdq_pkg::DATA_W-1:0] data);
        t_deque_rsp p;
        int         idx;
        idx    = pos;
        p.rd   = '0;
        p.st   = bdq_pkg::STAT_OK;
        case (kind)
            bdq_pkg::REQ_PUSH_BACK, bdq_pkg::REQ_PUSH_FRONT: begin
                if (shadow_count >= CAP) begin
                    p.st = bdq_pkg::STAT_FULL;
                end else if (kind == bdq_pkg::REQ_PUSH_BACK) begin
                    shadow_store[(shadow_front + shadow_count) % CAP] = data;
                    shadow_count++;
                end else begin
                    shadow_front = (shadow_front + CAP - 1) % CAP;
                    shadow_store[shadow_front] = data;
                    shadow_count++;
                end
            end
            bdq_pkg::REQ_POP_BACK, bdq_pkg::REQ_POP_FRONT: begin
                if (shadow_count == 0) begin
                    p.st = bdq_pkg::STAT_EMPTY;
                end else begin
                    if (kind == bdq_pkg::REQ_POP_FRONT)
                        shadow_front = (shadow_front + 1) % CAP;
                    shadow_count--;
                end
            end
            bdq_pkg::REQ_READ_AT, bdq_pkg::REQ_WRITE_AT: begin
                if (idx < 0)
                    p.st = bdq_pkg::STAT_NEG;
                else if (idx >= shadow_count)
                    p.st = bdq_pkg::STAT_RANGE;
                else if (kind == bdq_pkg::REQ_READ_AT)
                    p.rd = shadow_store[(shadow_front + idx) % CAP];
                else
                    shadow_store[(shadow_front + idx) % CAP] = data;
            end
            bdq_pkg::REQ_READ_BACK: begin
                if (idx < 1 || idx > shadow_count)
                    p.st = bdq_pkg::STAT_BACKNUM;
                else
                    p.rd = shadow_store[(shadow_front + shadow_count - idx) % CAP];
            end
            default: ;
        endcase
        p.fill = bdq_pkg::FILL_W'(shadow_count);
        return p;
    endfunction

    // valid stays high across back-to-back items; it is only lowered for a gap
    task automatic send_req(logic [bdq_pkg::REQ_W-1:0] kind, int pos,
                            logic signed [bdq_pkg::DATA_W-1:0] data);
        int gap;
        gap = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_bus.valid    <= 1'b1;
        req_bus.req_type <= kind;
        req_bus.position <= bdq_pkg::POS_W'(pos);
        req_bus.value    <= data;
        @(posedge i_clk);
        while (!req_bus.ready) @(posedge i_clk);
        pending_rsp.push_back(predict_response(kind, bdq_pkg::POS_W'(pos), data));
        items_sent++;
    endtask

    task automatic test_empty_errors();
        send_req(bdq_pkg::REQ_POP_BACK, 0, 32'sd11);
        send_req(bdq_pkg::REQ_POP_FRONT, 0, 32'sd12);
        send_req(bdq_pkg::REQ_READ_AT, 0, 32'sd0);
        send_req(bdq_pkg::REQ_READ_BACK, 1, 32'sd0);
        send_req(bdq_pkg::REQ_WRITE_AT, -64, 32'sd13);
        send_req(REQ_UNUSED, 63, -32'sd1);
    endtask

    task automatic test_edge_values();
        send_req(bdq_pkg::REQ_PUSH_BACK, 0, 32'sh7fff_ffff);
        send_req(bdq_pkg::REQ_PUSH_FRONT, 0, 32'sh8000_0000);
        send_req(bdq_pkg::REQ_PUSH_BACK, -1, 32'sd0);
        send_req(bdq_pkg::REQ_PUSH_FRONT, 63, -32'sd1);
        send_req(bdq_pkg::REQ_READ_AT, 0, 32'sd0);
        send_req(bdq_pkg::REQ_READ_AT, 3, 32'sd0);
        send_req(bdq_pkg::REQ_READ_AT, 4, 32'sd0);
        send_req(bdq_pkg::REQ_READ_AT, 63, 32'sd0);
        send_req(bdq_pkg::REQ_READ_AT, -64, 32'sd0);
        send_req(bdq_pkg::REQ_READ_BACK, 1, 32'sd0);
        send_req(bdq_pkg::REQ_READ_BACK, 4, 32'sd0);
        send_req(bdq_pkg::REQ_READ_BACK, 5, 32'sd0);
        send_req(bdq_pkg::REQ_READ_BACK, 0, 32'sd0);
        send_req(bdq_pkg::REQ_READ_BACK, -1, 32'sd0);
        send_req(bdq_pkg::REQ_WRITE_AT, 2, 32'sh5a5a_5a5a);
        send_req(bdq_pkg::REQ_READ_AT, 2, 32'sd0);
        send_req(bdq_pkg::REQ_WRITE_AT, -1, 32'sd1);
        send_req(bdq_pkg::REQ_WRITE_AT, 4, 32'sd1);
        send_req(bdq_pkg::REQ_POP_BACK, 0, 32'sd0);
        send_req(bdq_pkg::REQ_POP_FRONT, 0, 32'sd0);
    endtask

    // fill past capacity, poke around, then drain past empty; twice so the ring wraps
    task automatic test_fill_and_wrap();
        repeat (2) begin
            idle_on = $urandom_range(0, 1);
            repeat (CAP + 2)
                send_req($urandom_range(0, 1) ? bdq_pkg::REQ_PUSH_FRONT
                                              : bdq_pkg::REQ_PUSH_BACK,
                         $urandom_range(0, 127) - 64, $urandom);
            send_req(bdq_pkg::REQ_READ_AT, CAP - 1, $urandom);
            send_req(bdq_pkg::REQ_READ_BACK, CAP, $urandom);
            send_req(bdq_pkg::REQ_WRITE_AT, $urandom_range(0, CAP - 1), $urandom);
            send_req(bdq_pkg::REQ_READ_BACK, CAP + 1, $urandom);
            repeat (CAP + 1)
                send_req($urandom_range(0, 1) ? bdq_pkg::REQ_POP_FRONT
                                              : bdq_pkg::REQ_POP_BACK,
                         $urandom_range(0, 127) - 64, $urandom);
        end
    endtask

    task automatic test_random_mix(int n_items);
        int                        mode;
        int                        roll;
        int                        push_lim;
        int                        pop_lim;
        int                        pos;
        logic [bdq_pkg::REQ_W-1:0] kind;
        for (int i = 0; i < n_items; i++) begin
            // phases: 0 fill-heavy, 1 drain-heavy, 2 moderate (pushes slightly above pops)
            if (i % 40 == 0) begin
                mode    = $urandom_range(0, 2);
                idle_on = ($urandom_range(0, 3) != 0);
            end
            roll = $urandom_range(0, 99);
            if (roll < 8) begin
                kind = bdq_pkg::REQ_W'($urandom_range(0, 7));
                pos  = $urandom_range(0, 127) - 64;
            end else begin
                push_lim = (mode == 0) ? 55 : (mode == 1) ? 20 : 35;
                pop_lim  = push_lim + ((mode == 1) ? 45 : 25);
                roll     = $urandom_range(0, 99);
                if (roll < push_lim)
                    kind = $urandom_range(0, 1) ? bdq_pkg::REQ_PUSH_FRONT
                                                : bdq_pkg::REQ_PUSH_BACK;
                else if (roll < pop_lim)
                    kind = $urandom_range(0, 1) ? bdq_pkg::REQ_POP_FRONT
                                                : bdq_pkg::REQ_POP_BACK;
                else
                    case ($urandom_range(0, 2))
                        0:       kind = bdq_pkg::REQ_READ_AT;
                        1:       kind = bdq_pkg::REQ_WRITE_AT;
                        default: kind = bdq_pkg::REQ_READ_BACK;
                    endcase
                if (shadow_count == 0 || $urandom_range(0, 7) == 0)
                    pos = $urandom_range(0, 127) - 64;
                else if (kind == bdq_pkg::REQ_READ_BACK)
                    pos = $urandom_range(1, shadow_count);
                else
                    pos = $urandom_range(0, shadow_count - 1);
            end
            send_req(kind, pos, $urandom);
        end
    endtask

    // result side: random stalls, each accepted item checked against the oldest prediction
    initial begin
        t_deque_rsp exp;
        int         stall;
        rsp_bus.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
            if (stall > 0) begin
                rsp_bus.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp_bus.ready <= 1'b1;
            @(posedge i_clk);
            while (!rsp_bus.valid) @(posedge i_clk);
            results_seen++;
            status_seen[rsp_bus.status]++;
            if (pending_rsp.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result: read_value %0d status %0d fill %0d",
                         $time, rsp_bus.read_value, rsp_bus.status, rsp_bus.fill_count);
            end else begin
                exp = pending_rsp.pop_front();
                if (rsp_bus.read_value !== exp.rd) begin
                    mismatch_count++;
                    $display("%0t: read_value expected %0d actual %0d",
                             $time, exp.rd, rsp_bus.read_value);
                end
                if (rsp_bus.status !== exp.st) begin
                    mismatch_count++;
                    $display("%0t: status expected %0d actual %0d",
                             $time, exp.st, rsp_bus.status);
                end
                if (rsp_bus.fill_count !== exp.fill) begin
                    mismatch_count++;
                    $display("%0t: fill_count expected %0d actual %0d",
                             $time, exp.fill, rsp_bus.fill_count);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                 $time, WATCHDOG_LIMIT, pending_rsp.size());
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        items_sent       = 0;
        shadow_front     = 0;
        shadow_count     = 0;
        idle_on          = 1'b1;
        i_rst_n          <= 1'b0;
        req_bus.valid    <= 1'b0;
        req_bus.req_type <= '0;
        req_bus.position <= '0;
        req_bus.value    <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_errors();
        test_edge_values();
        test_fill_and_wrap();
        test_random_mix(RANDOM_ITEMS);
        req_bus.valid <= 1'b0;

        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("%0d requests, %0d results; ok %0d full %0d empty %0d",
                 items_sent, results_seen, status_seen[bdq_pkg::STAT_OK],
                 status_seen[bdq_pkg::STAT_FULL], status_seen[bdq_pkg::STAT_EMPTY]);
        $display("negative index %0d, out of range %0d, bad from-back number %0d",
                 status_seen[bdq_pkg::STAT_NEG], status_seen[bdq_pkg::STAT_RANGE],
                 status_seen[bdq_pkg::STAT_BACKNUM]);
        if (mismatch_count == 0 && pending_rsp.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== bounded_deque_with_index_access_top.f =====
rtl/core/bdq_pkg.sv
rtl/core/bdq_if.sv
rtl/core/bdq_ctrl.sv
rtl/core/bdq_dp.sv
rtl/core/bounded_deque_with_index_access_top.sv
sim/bounded_deque_with_index_access_top_tb.sv
